>>> design/magnetometer_axis_moving_average_top_assert.svh
// Assertion macros shared by the magnetometer moving-average RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MAGNETOMETER_AXIS_MOVING_AVERAGE_TOP_ASSERT_SVH
`define MAGNETOMETER_AXIS_MOVING_AVERAGE_TOP_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define MAG_AVG_ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("mag_avg invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define MAG_AVG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mag_avg implication violated");

// The consequent holds in the cycle after the antecedent.
`define MAG_AVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mag_avg sequence violated");

`endif

>>> design/mag_avg_pkg.sv
// Shared types, constants and the sample merge function for the magnetometer
// moving-average block. Has no dependencies.
package mag_avg_pkg;

  localparam int AXIS_W                = 2;
  localparam int BYTE_W                = 8;
  localparam int SAMPLE_W              = 13;
  localparam int SAMPLE_SHIFT          = 3;
  localparam int WINDOW_LENGTH_DEFAULT = 10;
  localparam int FIFO_DEPTH            = 8;
  localparam int S_TDATA_W             = 16;
  localparam int M_TDATA_W             = 32;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [BYTE_W-1:0] XY_LOW_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] Z_LOW_MASK  = 8'hFE;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] sample;
  } result_t;

  // Joins the masked bytes into a 16-bit word and divides by eight, rounding
  // towards zero.
  function automatic logic signed [SAMPLE_W-1:0] merge_sample(
    input logic [AXIS_W-1:0] axis,
    input logic [BYTE_W-1:0] lo,
    input logic [BYTE_W-1:0] hi
  );
    logic [BYTE_W-1:0]          mask;
    logic signed [2*BYTE_W-1:0] word;
    logic signed [2*BYTE_W-1:0] shifted;
    logic [2*BYTE_W-1:0]        quot;
    mask    = (axis == AXIS_Z) ? Z_LOW_MASK : XY_LOW_MASK;
    word    = {hi, lo & mask};
    shifted = word >>> SAMPLE_SHIFT;
    quot    = shifted + (2*BYTE_W)'(word[2*BYTE_W-1] && (word[SAMPLE_SHIFT-1:0] != '0));
    return quot[SAMPLE_W-1:0];
  endfunction

endpackage

>>> design/magnetometer_axis_moving_average_top.sv
// Top level of the per-axis magnetometer moving-average filter: sample ring
// memory, running sums and the output queue. Depends on mag_avg_pkg,
// mag_avg_mean_div, mag_avg_fifo and the assertion header.
//
//   channel   direction  fields
//   s_axis    in         tdata: low_byte, high_byte; tuser: axis_select
//   m_axis    out        tdata: axis_sample, axis_average
//
// One word is accepted every cycle while s_axis_tready is high; a result
// reaches m_axis through the ring read, the sum update, the divider register
// and the output queue. A word with axis selector 3 is taken and dropped.
// s_axis_tready depends only on registers: it falls once eight words are held
// between the ring stage and the output queue, so m_axis stalls back up there.
// Reset is synchronous; the ring needs no clearing pass, as per-entry valid
// bits make unwritten entries read as zero.
module magnetometer_axis_moving_average_top #(
  parameter int WINDOW_LENGTH = mag_avg_pkg::WINDOW_LENGTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // low_byte [7:0], high_byte [15:8]
  input  logic [mag_avg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // axis_select [1:0]
  input  logic [mag_avg_pkg::AXIS_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // axis_sample [12:0], axis_average [25:13], zero [31:26]
  output logic [mag_avg_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import mag_avg_pkg::*;
  `include "magnetometer_axis_moving_average_top_assert.svh"

  localparam int POS_W      = $clog2(WINDOW_LENGTH);
  localparam int ADDR_W     = AXIS_W + POS_W;
  localparam int RING_DEPTH = 1 << ADDR_W;
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LENGTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_LIMIT  = (1 << (SAMPLE_W - 1)) * WINDOW_LENGTH;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);

  logic [AXIS_W-1:0]          in_axis;
  logic [BYTE_W-1:0]          in_low;
  logic [BYTE_W-1:0]          in_high;
  logic                       s_accept;
  logic                       axis_ok;
  logic                       take;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [POS_W-1:0]           pos [3];
  logic [POS_W-1:0]           pos_sel;
  logic [ADDR_W-1:0]          ring_addr;

  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_rdata;
  logic [RING_DEPTH-1:0]      ring_valid;

  logic                       v1;
  logic                       old_valid1;
  logic [AXIS_W-1:0]          axis1;
  logic signed [SAMPLE_W-1:0] sample1;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SUM_W-1:0]    win_sum [3];
  logic signed [SUM_W-1:0]    sum_cur;
  logic signed [SUM_W-1:0]    sum_new;

  logic                       v2;
  logic signed [SUM_W-1:0]    sum2;
  logic signed [SAMPLE_W-1:0] sample2;

  logic                       div_valid;
  result_t                    div_result;
  result_t                    fifo_data;
  logic [OCC_W-1:0]           fifo_count;
  logic [OCC_W-1:0]           occupancy;

  assign in_axis  = s_axis_tuser;
  assign in_low   = s_axis_tdata[BYTE_W-1:0];
  assign in_high  = s_axis_tdata[2*BYTE_W-1:BYTE_W];
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign axis_ok  = (in_axis == AXIS_X) || (in_axis == AXIS_Y) || (in_axis == AXIS_Z);
  assign take     = s_accept && axis_ok;

  assign in_sample = merge_sample(in_axis, in_low, in_high);

  always_comb begin
    case (in_axis)
      AXIS_X:  pos_sel = pos[0];
      AXIS_Y:  pos_sel = pos[1];
      AXIS_Z:  pos_sel = pos[2];
      default: pos_sel = '0;
    endcase
  end

  assign ring_addr = {in_axis, pos_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
    end else if (take) begin
      pos[in_axis] <= (pos_sel == POS_LAST) ? '0 : pos_sel + 1'b1;
    end
  end

  // The new sample overwrites its slot in the same cycle that the old one is
  // read out, so the write never races a later read of the same entry.
  always_ff @(posedge clk) begin
    if (take) begin
      ring_mem[ring_addr] <= in_sample;
    end
    ring_rdata <= ring_mem[ring_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
    end else if (take) begin
      ring_valid[ring_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    old_valid1 <= ring_valid[ring_addr];
    axis1      <= in_axis;
    sample1    <= in_sample;
    sum2       <= sum_new;
    sample2    <= sample1;
  end

  assign old_sample = old_valid1 ? ring_rdata : '0;

  always_comb begin
    case (axis1)
      AXIS_X:  sum_cur = win_sum[0];
      AXIS_Y:  sum_cur = win_sum[1];
      AXIS_Z:  sum_cur = win_sum[2];
      default: sum_cur = '0;
    endcase
  end

  assign sum_new = sum_cur + SUM_W'(sample1) - SUM_W'(old_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum[0] <= '0;
      win_sum[1] <= '0;
      win_sum[2] <= '0;
    end else if (v1) begin
      win_sum[axis1] <= sum_new;
    end
  end

  mag_avg_mean_div #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_mean_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .in_sum     (sum2),
    .in_sample  (sample2),
    .out_valid  (div_valid),
    .out_result (div_result)
  );

  mag_avg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (div_valid),
    .push_data (div_result),
    .pop_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (fifo_data),
    .count     (fifo_count)
  );

  // Every word past the ring stage holds a queue slot until it leaves.
  assign occupancy     = OCC_W'(v1) + OCC_W'(v2) + OCC_W'(div_valid) + fifo_count;
  assign s_axis_tready = (occupancy < OCC_W'(FIFO_DEPTH));
  assign m_axis_tdata  = M_TDATA_W'({fifo_data.average, fifo_data.sample});

  `MAG_AVG_ASSERT_HOLDS(a_credit_bound, clk, rst, occupancy <= OCC_W'(FIFO_DEPTH))
  `MAG_AVG_ASSERT_NEXT(a_dropped_word, clk, rst, s_accept && !axis_ok, !v1)
  `MAG_AVG_ASSERT_HOLDS(a_pos_bound, clk, rst, pos[0] <= POS_LAST && pos[1] <= POS_LAST && pos[2] <= POS_LAST)
  `MAG_AVG_ASSERT_HOLDS(a_sum_bound, clk, rst, win_sum[0] >= -SUM_LIMIT && win_sum[0] < SUM_LIMIT)
  `MAG_AVG_ASSERT_NEXT(a_ring_written, clk, rst, take, ring_valid[$past(ring_addr)])

endmodule

>>> design/mag_avg_mean_div.sv
// Two-stage window mean: magnitude of the running sum, then division by the
// window length through a reciprocal multiply. Depends on mag_avg_pkg.
module mag_avg_mean_div #(
  parameter int WINDOW_LENGTH = mag_avg_pkg::WINDOW_LENGTH_DEFAULT
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  logic signed [mag_avg_pkg::SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0] in_sum,
  input  logic signed [mag_avg_pkg::SAMPLE_W-1:0]           in_sample,
  output logic                                              out_valid,
  output mag_avg_pkg::result_t                              out_result
);
  import mag_avg_pkg::*;

  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LENGTH);
  localparam int LOG_W  = $clog2(WINDOW_LENGTH);
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int PROD_W = 2 * SUM_W + 1;
  // Rounded-up reciprocal; exact floor for every magnitude below 2**SUM_W.
  localparam longint unsigned RECIP = ((longint'(1) << SHIFT) + WINDOW_LENGTH - 1)
                                      / WINDOW_LENGTH;
  localparam logic [SUM_W:0] RECIP_C = (SUM_W + 1)'(RECIP);

  logic                       valid;
  logic                       neg;
  logic [SUM_W-1:0]           mag;
  logic signed [SAMPLE_W-1:0] sample;
  logic [PROD_W-1:0]          prod;
  logic [SAMPLE_W-1:0]        quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    neg    <= in_sum[SUM_W-1];
    mag    <= in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
    sample <= in_sample;
  end

  assign prod = PROD_W'(mag) * PROD_W'(RECIP_C);
  assign quot = prod[SHIFT +: SAMPLE_W];

  assign out_valid          = valid;
  assign out_result.sample  = sample;
  assign out_result.average = neg ? (SAMPLE_W'(0) - quot) : quot;

endmodule

>>> design/mag_avg_fifo.sv
// Result queue on the master side; it absorbs every word in flight when the
// consumer stalls. Depends on mag_avg_pkg and the assertion header.
module mag_avg_fifo (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           push,
  input  mag_avg_pkg::result_t                           push_data,
  input  logic                                           pop_ready,
  output logic                                           out_valid,
  output mag_avg_pkg::result_t                           out_data,
  output logic [$clog2(mag_avg_pkg::FIFO_DEPTH+1)-1:0]   count
);
  import mag_avg_pkg::*;
  `include "magnetometer_axis_moving_average_top_assert.svh"

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && pop_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `MAG_AVG_ASSERT_HOLDS(a_no_overflow, clk, rst, !(push && !pop && count == CNT_W'(FIFO_DEPTH)))
  `MAG_AVG_ASSERT_HOLDS(a_count_bound, clk, rst, count <= CNT_W'(FIFO_DEPTH))
  `MAG_AVG_ASSERT_NEXT(a_count_grows, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule
